FILE: rtl/core/cosh_pkg.sv
// ----------------------------------------------------------------------------
// cosh_pkg
// Shared types and constants for the count-sorted sparse histogram.
// ----------------------------------------------------------------------------
package cosh_pkg;

    localparam int MAX_TOPICS = 1024;
    localparam int COUNT_BITS = 32;

    localparam int TOPIC_W = 10;
    localparam int RANK_W  = 10;
    localparam int AMT_W   = 32;
    localparam int RCNT_W  = 32;
    localparam int CFG_W   = 11;
    localparam int TOTAL_W = 11;

    localparam int IDX_W = $clog2(MAX_TOPICS);
    localparam int ENT_W = $clog2(MAX_TOPICS + 1);
    localparam int ADD_W = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;

    localparam int GROUP_SIZE = (MAX_TOPICS < 32) ? MAX_TOPICS : 32;
    localparam int NUM_GROUPS = (MAX_TOPICS + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0]      TOPICS_RESET = CFG_W'(1024);

    typedef enum logic [1:0] {
        OP_INC   = 2'd0,
        OP_DEC   = 2'd1,
        OP_QUERY = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INC,
        SH_DEC,
        SH_REM
    } shift_mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_GATH,
        S_CALC,
        S_SHIFT,
        S_DONE
    } fsm_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        shift_mode_t             mode;
        logic                    sel_pos;
        logic [TOPIC_W-1:0]      tp;
        logic [RANK_W-1:0]       pos;
        logic [COUNT_BITS-1:0]   c;
        logic [IDX_W-1:0]        i;
        logic [ENT_W-1:0]        n;
    } bcast_t;

    // one selected entry, zero when not selected so groups can OR
    typedef struct packed {
        logic                    hit;
        logic [TOPIC_W-1:0]      topic;
        logic [COUNT_BITS-1:0]   count;
        logic [IDX_W-1:0]        idx;
    } hit_t;

endpackage

FILE: rtl/core/count_sorted_sparse_histogram.sv
// ----------------------------------------------------------------------------
// count_sorted_sparse_histogram
// List of (topic, count) entries kept in descending count order.
// ----------------------------------------------------------------------------
// One cell per list slot; every cell compares its entry with the item in
// parallel and a two-level registered OR tree over groups of 32 cells picks
// the matching entry. One item at a time: a query, a read by rank or a
// rejected item raises out_valid after two tree stages, decide and load;
// an increment or nonzero decrement searches, shifts the whole row at
// once, searches again for the new rank, then decides and loads, and a
// decrement to zero searches, decides, removes the entry and loads.
// in_ready rises in the same cycle as out_valid, when the result is loaded.
// A stalled output register holds the block in its last step until it frees.
// A result may wait in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module count_sorted_sparse_histogram
    import cosh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [TOPIC_W-1:0]   topic,
    input  logic [AMT_W-1:0]     amount,
    input  logic [RANK_W-1:0]    position,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [TOPIC_W-1:0]   result_topic,
    output logic [RCNT_W-1:0]    result_count,
    output logic [RANK_W-1:0]    result_rank,
    output logic [TOTAL_W-1:0]   entry_total
);

    fsm_t                  state_reg, state_next;
    logic                  pass_reg, pass_next;
    shift_mode_t           mode_reg, mode_next;
    logic [ENT_W-1:0]      n_reg, n_next;
    logic [CFG_W-1:0]      topics_reg;
    logic                  out_valid_reg, out_valid_next;

    op_t                   op_reg, op_next;
    logic [TOPIC_W-1:0]    tp_reg, tp_next;
    logic [AMT_W-1:0]      amt_reg, amt_next;
    logic [RANK_W-1:0]     pos_reg, pos_next;
    logic [COUNT_BITS-1:0] c_reg, c_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    status_t               res_status_reg, res_status_next;
    logic [TOPIC_W-1:0]    res_topic_reg, res_topic_next;
    logic [RCNT_W-1:0]     res_count_reg, res_count_next;
    logic [RANK_W-1:0]     res_rank_reg, res_rank_next;
    status_t               out_status_reg, out_status_next;
    logic [TOPIC_W-1:0]    out_topic_reg, out_topic_next;
    logic [RCNT_W-1:0]     out_count_reg, out_count_next;
    logic [RANK_W-1:0]     out_rank_reg, out_rank_next;
    logic [TOTAL_W-1:0]    out_total_reg, out_total_next;

    hit_t                  found_reg, found_next;
    bcast_t                bc;

    logic [TOPIC_W-1:0]    cell_topic  [MAX_TOPICS];
    logic [COUNT_BITS-1:0] cell_count  [MAX_TOPICS];
    logic                  cell_ahead  [MAX_TOPICS];
    logic                  cell_after  [MAX_TOPICS];
    hit_t                  leaf        [NUM_GROUPS][GROUP_SIZE];
    hit_t                  group_sum   [NUM_GROUPS];

    logic                  tp_ok;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [ADD_W-1:0]      sum;
    logic [COUNT_BITS-1:0] c_inc;
    logic [COUNT_BITS-1:0] c_dec;
    logic                  too_small;

    // ---------------- broadcast ----------------
    always_comb
    begin
        bc.mode    = (state_reg == S_SHIFT) ? mode_reg : SH_HOLD;
        bc.sel_pos = !pass_reg && (op_reg == OP_READ);
        bc.tp      = tp_reg;
        bc.pos     = pos_reg;
        bc.c       = c_reg;
        bc.i       = i_reg;
        bc.n       = n_reg;
    end

    // ---------------- row of cells ----------------
    for (genvar k = 0; k < MAX_TOPICS; k++)
    begin : g_cell
        logic [TOPIC_W-1:0]    l_topic, r_topic;
        logic [COUNT_BITS-1:0] l_count, r_count;
        logic                  l_ahead, r_after;

        if (k == 0)
        begin : g_first
            assign l_topic = '0;
            assign l_count = '0;
            assign l_ahead = 1'b1;
        end
        else
        begin : g_left
            assign l_topic = cell_topic[k-1];
            assign l_count = cell_count[k-1];
            assign l_ahead = cell_ahead[k-1];
        end

        if (k == MAX_TOPICS - 1)
        begin : g_last
            assign r_topic = '0;
            assign r_count = '0;
            assign r_after = 1'b0;
        end
        else
        begin : g_right
            assign r_topic = cell_topic[k+1];
            assign r_count = cell_count[k+1];
            assign r_after = cell_after[k+1];
        end

        cosh_cell u_cell (
            .clk         (clk),
            .idx         (IDX_W'(k)),
            .bc          (bc),
            .left_topic  (l_topic),
            .left_count  (l_count),
            .left_ahead  (l_ahead),
            .right_topic (r_topic),
            .right_count (r_count),
            .right_after (r_after),
            .topic       (cell_topic[k]),
            .count       (cell_count[k]),
            .ahead       (cell_ahead[k]),
            .after       (cell_after[k]),
            .leaf        (leaf[k / GROUP_SIZE][k % GROUP_SIZE])
        );
    end

    for (genvar k = MAX_TOPICS; k < NUM_GROUPS * GROUP_SIZE; k++)
    begin : g_pad
        assign leaf[k / GROUP_SIZE][k % GROUP_SIZE] = '0;
    end

    // ---------------- select tree ----------------
    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_group
        cosh_group u_group (
            .clk       (clk),
            .leaf      (leaf[g]),
            .group_sum (group_sum[g])
        );
    end

    always_comb
    begin
        found_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            found_next = hit_t'(found_next | group_sum[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
    end

    // ---------------- arithmetic on the found entry ----------------
    assign tp_ok     = (32'(tp_reg) < 32'(topics_reg)) && (32'(tp_reg) < MAX_TOPICS);
    assign old_cnt   = found_reg.hit ? found_reg.count : '0;
    assign sum       = ADD_W'(old_cnt) + ADD_W'(amt_reg);
    assign c_inc     = (sum >= ADD_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_BITS-1:0];
    assign too_small = ADD_W'(found_reg.count) < ADD_W'(amt_reg);
    assign c_dec     = found_reg.count - COUNT_BITS'(amt_reg);

    // ---------------- control ----------------
    always_comb
    begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        mode_next       = mode_reg;
        n_next          = n_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        tp_next         = tp_reg;
        amt_next        = amt_reg;
        pos_next        = pos_reg;
        c_next          = c_reg;
        i_next          = i_reg;
        res_status_next = res_status_reg;
        res_topic_next  = res_topic_reg;
        res_count_next  = res_count_reg;
        res_rank_next   = res_rank_reg;
        out_status_next = out_status_reg;
        out_topic_next  = out_topic_reg;
        out_count_next  = out_count_reg;
        out_rank_next   = out_rank_reg;
        out_total_next  = out_total_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op_t'(opcode);
                    tp_next    = topic;
                    amt_next   = amount;
                    pos_next   = position;
                    pass_next  = 1'b0;
                    mode_next  = SH_HOLD;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                state_next = S_GATH;
            end
            S_GATH:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next      = S_DONE;
                res_status_next = ST_OK;
                res_topic_next  = tp_reg;
                res_count_next  = '0;
                res_rank_next   = '0;
                if (pass_reg)
                begin
                    res_count_next = RCNT_W'(found_reg.count);
                    res_rank_next  = RANK_W'(found_reg.idx);
                end
                else if (op_reg == OP_READ)
                begin
                    if (32'(pos_reg) < 32'(n_reg))
                    begin
                        res_topic_next = found_reg.topic;
                        res_count_next = RCNT_W'(found_reg.count);
                        res_rank_next  = pos_reg;
                    end
                    else
                    begin
                        res_status_next = ST_BAD;
                        res_topic_next  = '0;
                    end
                end
                else if (!tp_ok || ((op_reg != OP_QUERY) && (amt_reg == '0)))
                begin
                    res_status_next = ST_BAD;
                end
                else if (op_reg == OP_QUERY)
                begin
                    if (found_reg.hit)
                    begin
                        res_count_next = RCNT_W'(found_reg.count);
                        res_rank_next  = RANK_W'(found_reg.idx);
                    end
                end
                else if (op_reg == OP_INC)
                begin
                    if (!found_reg.hit && (32'(n_reg) >= MAX_TOPICS))
                    begin
                        res_status_next = ST_BAD;
                    end
                    else
                    begin
                        c_next     = c_inc;
                        i_next     = found_reg.hit ? found_reg.idx : IDX_W'(n_reg);
                        mode_next  = SH_INC;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    if (!found_reg.hit || too_small)
                    begin
                        res_status_next = ST_MISS;
                    end
                    else
                    begin
                        c_next     = c_dec;
                        i_next     = found_reg.idx;
                        mode_next  = (c_dec == '0) ? SH_REM : SH_DEC;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (mode_reg == SH_REM)
                begin
                    n_next     = n_reg - ENT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    if ((mode_reg == SH_INC) && (32'(i_reg) == 32'(n_reg)))
                    begin
                        n_next = n_reg + ENT_W'(1);
                    end
                    pass_next  = 1'b1;
                    state_next = S_FIND;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_topic_next  = res_topic_reg;
                    out_count_next  = res_count_reg;
                    out_rank_next   = res_rank_reg;
                    out_total_next  = TOTAL_W'(n_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= 1'b0;
            mode_reg      <= SH_HOLD;
            n_reg         <= '0;
            topics_reg    <= TOPICS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            mode_reg      <= mode_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                topics_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        tp_reg         <= tp_next;
        amt_reg        <= amt_next;
        pos_reg        <= pos_next;
        c_reg          <= c_next;
        i_reg          <= i_next;
        res_status_reg <= res_status_next;
        res_topic_reg  <= res_topic_next;
        res_count_reg  <= res_count_next;
        res_rank_reg   <= res_rank_next;
        out_status_reg <= out_status_next;
        out_topic_reg  <= out_topic_next;
        out_count_reg  <= out_count_next;
        out_rank_reg   <= out_rank_next;
        out_total_reg  <= out_total_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_topic = out_topic_reg;
    assign result_count = out_count_reg;
    assign result_rank  = out_rank_reg;
    assign entry_total  = out_total_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= MAX_TOPICS)
        else $error("entry count above capacity");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && mode_reg == SH_REM) |=> n_reg == $past(n_reg) - ENT_W'(1))
        else $error("removal did not shrink the list");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_BAD || status == ST_MISS))
        else $error("undefined status code");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> !in_ready)
        else $error("item accepted during a shift");
`endif

endmodule

FILE: rtl/core/cosh_cell.sv
// ----------------------------------------------------------------------------
// cosh_cell
// One list slot: holds a topic and count, shifts to/from its neighbors.
// ----------------------------------------------------------------------------
module cosh_cell
    import cosh_pkg::*;
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      idx,
    input  bcast_t                bc,
    input  logic [TOPIC_W-1:0]    left_topic,
    input  logic [COUNT_BITS-1:0] left_count,
    input  logic                  left_ahead,
    input  logic [TOPIC_W-1:0]    right_topic,
    input  logic [COUNT_BITS-1:0] right_count,
    input  logic                  right_after,
    output logic [TOPIC_W-1:0]    topic,
    output logic [COUNT_BITS-1:0] count,
    output logic                  ahead,
    output logic                  after,
    output hit_t                  leaf
);

    logic [TOPIC_W-1:0]    topic_reg;
    logic [TOPIC_W-1:0]    topic_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  valid;
    logic                  lt_i;
    logic                  gt_i;
    logic                  sel;

    assign valid = 32'(idx) < 32'(bc.n);
    assign lt_i  = idx < bc.i;
    assign gt_i  = idx > bc.i;

    // ahead: stays ahead of the insertion point on an increment
    // after: gets passed by the entry on a decrement
    assign ahead = lt_i && (count_reg >= bc.c);
    assign after = gt_i && valid && (count_reg > bc.c);

    always_comb
    begin
        topic_next = topic_reg;
        count_next = count_reg;
        unique case (bc.mode)
            SH_HOLD:
            begin
            end
            SH_INC:
            begin
                if (!gt_i && !ahead && left_ahead)
                begin
                    topic_next = bc.tp;
                    count_next = bc.c;
                end
                else if (!gt_i && !ahead)
                begin
                    topic_next = left_topic;
                    count_next = left_count;
                end
            end
            SH_DEC:
            begin
                if (!lt_i && !right_after && (!gt_i || after))
                begin
                    topic_next = bc.tp;
                    count_next = bc.c;
                end
                else if (!lt_i && right_after)
                begin
                    topic_next = right_topic;
                    count_next = right_count;
                end
            end
            SH_REM:
            begin
                if (!lt_i)
                begin
                    topic_next = right_topic;
                    count_next = right_count;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        topic_reg <= topic_next;
        count_reg <= count_next;
    end

    assign sel = bc.sel_pos ? (32'(idx) == 32'(bc.pos))
                            : (valid && (topic_reg == bc.tp));

    assign leaf  = sel ? hit_t'{1'b1, topic_reg, count_reg, idx} : '0;
    assign topic = topic_reg;
    assign count = count_reg;

endmodule

FILE: rtl/core/cosh_group.sv
// ----------------------------------------------------------------------------
// cosh_group
// First level of the select tree: ORs the hits of one group of cells.
// ----------------------------------------------------------------------------
module cosh_group
    import cosh_pkg::*;
(
    input  logic clk,
    input  hit_t leaf [GROUP_SIZE],
    output hit_t group_sum
);

    hit_t sum_reg;
    hit_t sum_next;

    // at most one cell is selected, so OR acts as a mux
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < GROUP_SIZE; k++)
        begin
            sum_next = hit_t'(sum_next | leaf[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign group_sum = sum_reg;

endmodule

FILE: dv/cosh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosh_checker
// Watches both channels of the histogram and the config port, keeps its own
// count-ordered list, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module cosh_checker
    import cosh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [TOPIC_W-1:0]   topic,
    input  logic [AMT_W-1:0]     amount,
    input  logic [RANK_W-1:0]    position,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [1:0]           status,
    input  logic [TOPIC_W-1:0]   result_topic,
    input  logic [RCNT_W-1:0]    result_count,
    input  logic [RANK_W-1:0]    result_rank,
    input  logic [TOTAL_W-1:0]   entry_total,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen
);

    typedef struct packed {
        status_t             st;
        logic [TOPIC_W-1:0]  tp;
        logic [RCNT_W-1:0]   cnt;
        logic [RANK_W-1:0]   rank;
        logic [TOTAL_W-1:0]  total;
    } hist_result_t;

    logic [TOPIC_W-1:0]    list_topic [MAX_TOPICS];
    logic [COUNT_BITS-1:0] list_count [MAX_TOPICS];
    int                    list_len;
    logic [CFG_W-1:0]      topic_limit;
    hist_result_t          expected_results [$];

    function automatic int find_slot(logic [TOPIC_W-1:0] tp);
        for (int k = 0; k < list_len; k++)
            if (list_topic[k] == tp)
                return k;
        return list_len;
    endfunction

    function automatic hist_result_t pack_result(status_t st, logic [TOPIC_W-1:0] tp,
                                                 logic [RCNT_W-1:0] cnt, int rank);
        hist_result_t r;
        r.st = st;
        r.tp = tp;
        r.cnt = cnt;
        r.rank = RANK_W'(rank);
        r.total = TOTAL_W'(list_len);
        return r;
    endfunction

    function automatic hist_result_t apply_item(op_t op, logic [TOPIC_W-1:0] tp,
                                                logic [AMT_W-1:0] amt,
                                                logic [RANK_W-1:0] pos);
        int k;
        logic [COUNT_BITS:0] sum;
        logic [COUNT_BITS-1:0] c;
        if (op == OP_READ) begin
            if (int'(pos) >= list_len)
                return pack_result(ST_BAD, '0, '0, 0);
            return pack_result(ST_OK, list_topic[pos], list_count[pos], pos);
        end
        if ({1'b0, tp} >= topic_limit || (op != OP_QUERY && amt == 0))
            return pack_result(ST_BAD, tp, '0, 0);
        k = find_slot(tp);
        case (op)
            OP_INC:
            begin
                if (k == list_len) begin
                    if (list_len >= MAX_TOPICS)
                        return pack_result(ST_BAD, tp, '0, 0);
                    c = '0;
                    list_len++;
                end
                else
                    c = list_count[k];
                sum = {1'b0, c} + amt;
                c = (sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
                while (k > 0 && c > list_count[k-1]) begin
                    list_topic[k] = list_topic[k-1];
                    list_count[k] = list_count[k-1];
                    k--;
                end
                list_topic[k] = tp;
                list_count[k] = c;
                return pack_result(ST_OK, tp, c, k);
            end
            OP_DEC:
            begin
                if (k == list_len || list_count[k] < amt)
                    return pack_result(ST_MISS, tp, '0, 0);
                c = list_count[k] - amt;
                if (c == 0) begin
                    for (; k + 1 < list_len; k++) begin
                        list_topic[k] = list_topic[k+1];
                        list_count[k] = list_count[k+1];
                    end
                    list_len--;
                    return pack_result(ST_OK, tp, '0, 0);
                end
                while (k + 1 < list_len && c < list_count[k+1]) begin
                    list_topic[k] = list_topic[k+1];
                    list_count[k] = list_count[k+1];
                    k++;
                end
                list_topic[k] = tp;
                list_count[k] = c;
                return pack_result(ST_OK, tp, c, k);
            end
            default:
            begin
                if (k == list_len)
                    return pack_result(ST_OK, tp, '0, 0);
                return pack_result(ST_OK, tp, list_count[k], k);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hist_result_t want;
        if (!rst_n) begin
            list_len = 0;
            topic_limit = TOPICS_RESET;
            expected_results.delete();
            fail_count = 0;
            results_seen = 0;
            pending = 0;
        end
        else begin
            if (cfg_wr_en)
                topic_limit = cfg_wr_data;
            if (in_valid && in_ready)
                expected_results.push_back(apply_item(op_t'(opcode), topic, amount, position));
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, topic", result_topic, 0);
                end
                else begin
                    want = expected_results.pop_front();
                    if (status != want.st)
                        report_mismatch("status", status, want.st);
                    if (result_topic != want.tp)
                        report_mismatch("result_topic", result_topic, want.tp);
                    if (result_count != want.cnt)
                        report_mismatch("result_count", result_count, want.cnt);
                    if (result_rank != want.rank)
                        report_mismatch("result_rank", result_rank, want.rank);
                    if (entry_total != want.total)
                        report_mismatch("entry_total", entry_total, want.total);
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the count-sorted histogram: directed corner items, then
// phases of random traffic over several topic limits, with random gaps and
// output stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb
    import cosh_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           opcode = '0;
    logic [TOPIC_W-1:0]   topic = '0;
    logic [AMT_W-1:0]     amount = '0;
    logic [RANK_W-1:0]    position = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           status;
    logic [TOPIC_W-1:0]   result_topic;
    logic [RCNT_W-1:0]    result_count;
    logic [RANK_W-1:0]    result_rank;
    logic [TOTAL_W-1:0]   entry_total;

    int  fail_count;
    int  pending;
    int  results_seen;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    count_sorted_sparse_histogram dut (.*);

    cosh_checker checker_i (.*);

    // receiver stalls ~31% except in the steady stretch
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 31);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // valid is held into the next call, which drops it for any random gap, so each negedge sees one update
    task automatic send_item(op_t op, logic [TOPIC_W-1:0] tp, logic [AMT_W-1:0] amt,
                             logic [RANK_W-1:0] pos);
        while (!steady && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        topic <= tp;
        amount <= amt;
        position <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic set_topic_limit(logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [AMT_W-1:0] random_amount();
        case ($urandom_range(9))
            0: return 32'hFFFF_FFFF;
            1: return $urandom();
            2: return 32'h8000_0000 | $urandom_range(3);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // mostly valid traffic over a small topic pool so entries collide and reorder
    task automatic random_phase(int n, int pool);
        int r;
        logic [TOPIC_W-1:0] tp;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            tp = (r % 10 == 0) ? TOPIC_W'($urandom()) : TOPIC_W'($urandom_range(pool - 1));
            if (r < 40)
                send_item(OP_INC, tp, random_amount(), RANK_W'($urandom()));
            else if (r < 65)
                send_item(OP_DEC, tp, ($urandom_range(19) == 0) ? '0 : random_amount(),
                          RANK_W'($urandom()));
            else if (r < 80)
                send_item(OP_QUERY, tp, $urandom(), RANK_W'($urandom()));
            else
                send_item(OP_READ, TOPIC_W'($urandom()), $urandom(),
                          RANK_W'($urandom_range(0, (r < 95) ? 12 : 1023)));
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners at the reset limit
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_INC, 10'd5, '0, '0);
        send_item(OP_DEC, 10'd5, 32'd1, '0);
        send_item(OP_QUERY, 10'd5, '0, '0);
        send_item(OP_INC, 10'd1023, 32'hFFFF_FFFF, 10'h3FF);
        send_item(OP_INC, 10'd1023, 32'd7, '0);
        send_item(OP_INC, 10'd0, 32'd3, '0);
        send_item(OP_INC, 10'd1, 32'd3, '0);
        send_item(OP_INC, 10'd2, 32'd9, '0);
        send_item(OP_INC, 10'd0, 32'd7, '0);
        send_item(OP_DEC, 10'd1023, 32'hFFFF_FFFE, '0);
        send_item(OP_DEC, 10'd2, 32'd10, '0);
        send_item(OP_DEC, 10'd0, 32'd10, '0);
        send_item(OP_QUERY, 10'd1, '0, '0);
        send_item(OP_QUERY, 10'd0, '0, '0);
        send_item(OP_READ, 10'h3FF, 32'hFFFF_FFFF, 10'd0);
        send_item(OP_READ, '0, '0, 10'd2);
        send_item(OP_READ, '0, '0, 10'h3FF);
        send_item(OP_DEC, 10'd1023, 32'd1, '0);

        set_topic_limit(11'd1);
        send_item(OP_INC, 10'd1, 32'd1, '0);
        send_item(OP_INC, 10'd0, 32'd2, '0);
        random_phase(150, 4);

        set_topic_limit(11'd16);
        random_phase(350, 20);

        steady = 1'b1;
        random_phase(150, 12);
        steady = 1'b0;

        set_topic_limit(11'd1024);
        random_phase(400, 40);

        set_topic_limit(11'd700);
        random_phase(230, 1024);

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("%0d items sent, %0d results checked over five topic limits",
                 items_sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cosh_pkg.sv
rtl/core/cosh_cell.sv
rtl/core/cosh_group.sv
rtl/core/count_sorted_sparse_histogram.sv
dv/cosh_checker.sv
dv/tb.sv
